// ----- rtl/core/pcht_pkg.sv -----
// pcht_pkg: shared types and constants of the pair count hash table
// used by pcht_mod, pcht_ctrl, pcht_dpath and pair_count_hash_table
package pcht_pkg;

  // configuration register
  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // hash multiplier on the first identifier
  localparam int unsigned HASH_MULT = 31;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_HIT  = 2'd0;
  localparam status_t STATUS_NEW  = 2'd1;
  localparam status_t STATUS_DROP = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch the pair, start the bucket modulo
    logic div_step;    // one remainder step
    logic head_rd;     // read the bucket head
    logic walk_start;  // start the chain walk from the head
    logic node_rd;     // read the node under the cursor
    logic advance;     // follow the link of the current node
    logic hit_wr;      // increment the matching node
    logic ins_wr;      // insert a new node at the chain head
    logic drop;        // pool full, flag the pair
    logic clr_step;    // clear one bucket head
    logic out_load;    // move the pending result to the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_last;
    logic clr_last;
    logic probe_ok;
    logic key_match;
    logic pool_full;
  } sts_t;

endpackage

// ----- rtl/core/pcht_mod.sv -----
// pcht_mod: iterative remainder unit, one dividend bit per step
// depends on pcht_pkg for the divisor width
module pcht_mod import pcht_pkg::*; #(
  parameter int unsigned HASH_W = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              step,
  input  logic [HASH_W-1:0] dividend,
  input  logic [CFG_W-1:0]  divisor,
  output logic [CFG_W-1:0]  rem,
  output logic              last
);

  localparam int unsigned CNT_W = (HASH_W > 1) ? $clog2(HASH_W) : 1;

  logic [HASH_W-1:0] quo_r;
  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [CFG_W-1:0]  div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CFG_W:0]    trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, quo_r[HASH_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CFG_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = CFG_W'(trial);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (step) begin
      quo_r <= quo_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r;
  assign last = (cnt_r == CNT_W'(HASH_W - 1));

endmodule

// ----- rtl/core/pcht_ctrl.sv -----
// pcht_ctrl: sequencer of the pair count hash table
// depends on pcht_pkg for the command and status structs
module pcht_ctrl import pcht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_HEAD,
    ST_HLOOK,
    ST_PROBE,
    ST_CMP,
    ST_MISS,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = ST_HLOOK;
      end
      ST_HLOOK: begin
        cmd.walk_start = 1'b1;
        state_nxt      = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts.probe_ok) begin
          cmd.node_rd = 1'b1;
          state_nxt   = ST_CMP;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_CMP: begin
        if (sts.key_match) begin
          cmd.hit_wr = 1'b1;
          state_nxt  = ST_RESULT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_PROBE;
        end
      end
      ST_MISS: begin
        if (sts.pool_full) begin
          cmd.drop = 1'b1;
        end else begin
          cmd.ins_wr = 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid follows loads and completed transactions
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/pcht_dpath.sv -----
// pcht_dpath: hash, bucket head memory, node pool memory and result registers
// depends on pcht_pkg and instantiates pcht_mod
module pcht_dpath import pcht_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned POOL_NODES  = 4096,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic [ID_BITS-1:0]    in_first_id,
  input  logic [ID_BITS-1:0]    in_second_id,
  output logic [COUNT_BITS-1:0] out_pair_count,
  output status_t               out_status
);

  localparam int unsigned HASH_W = ID_BITS + 6;
  localparam int unsigned BIDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NIDX_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned LINK_W = $clog2(POOL_NODES + 1);

  // configuration and pair registers
  logic [CFG_W-1:0]   cfg_r;
  logic [ID_BITS-1:0] first_r, second_r;
  logic [CFG_W-1:0]   active;
  logic [HASH_W-1:0]  hash;

  // modulo unit
  logic [CFG_W-1:0]   rem;
  logic               div_last;
  logic [BIDX_W-1:0]  bucket;

  // bucket heads
  logic               head_vld_mem [MAX_BUCKETS];
  logic [NIDX_W-1:0]  head_ptr_mem [MAX_BUCKETS];
  logic               head_vld_q;
  logic [NIDX_W-1:0]  head_ptr_q;
  logic [BIDX_W-1:0]  clr_cnt_r;

  // node pool
  logic [ID_BITS-1:0]    node_first_mem  [POOL_NODES];
  logic [ID_BITS-1:0]    node_second_mem [POOL_NODES];
  logic [COUNT_BITS-1:0] node_tally_mem  [POOL_NODES];
  logic [LINK_W-1:0]     node_link_mem   [POOL_NODES];
  logic [ID_BITS-1:0]    node_first_q, node_second_q;
  logic [COUNT_BITS-1:0] node_tally_q, tally_inc;
  logic [LINK_W-1:0]     node_link_q;

  // walk state
  logic [LINK_W-1:0]  cur_r, ins_link_r;
  logic [LINK_W-1:0]  steps_r, pool_used_r;
  logic [NIDX_W-1:0]  cur_idx, new_idx;

  // pending result
  logic [COUNT_BITS-1:0] pend_count_r, out_count_r;
  status_t               pend_status_r, out_status_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // bucket count in use, zero reads as one, capped at the table size
  always_comb begin
    if (cfg_r == '0) begin
      active = CFG_W'(1);
    end else if (32'(cfg_r) > 32'(MAX_BUCKETS)) begin
      active = CFG_W'(MAX_BUCKETS);
    end else begin
      active = cfg_r;
    end
  end

  assign hash = HASH_W'(HASH_W'(in_first_id) * HASH_W'(HASH_MULT)) + HASH_W'(in_second_id);

  // latch the pair
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r  <= in_first_id;
      second_r <= in_second_id;
    end
  end

  pcht_mod #(
    .HASH_W (HASH_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .step     (cmd.div_step),
    .dividend (hash),
    .divisor  (active),
    .rem      (rem),
    .last     (div_last)
  );

  assign bucket  = BIDX_W'(rem);
  assign cur_idx = cur_r[NIDX_W-1:0];
  assign new_idx = pool_used_r[NIDX_W-1:0];

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // head memory write port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      head_vld_mem[clr_cnt_r] <= 1'b0;
    end else if (cmd.ins_wr) begin
      head_vld_mem[bucket] <= 1'b1;
      head_ptr_mem[bucket] <= new_idx;
    end
  end

  // head memory read port
  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      head_vld_q <= head_vld_mem[bucket];
      head_ptr_q <= head_ptr_mem[bucket];
    end
  end

  // saturating increment of the matching node
  assign tally_inc = (node_tally_q == '1) ? node_tally_q : COUNT_BITS'(node_tally_q + 1'b1);

  // node memory write port
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      node_first_mem[new_idx]  <= first_r;
      node_second_mem[new_idx] <= second_r;
      node_tally_mem[new_idx]  <= COUNT_BITS'(1);
      node_link_mem[new_idx]   <= ins_link_r;
    end else if (cmd.hit_wr) begin
      node_tally_mem[cur_idx] <= tally_inc;
    end
  end

  // node memory read port
  always_ff @(posedge clk) begin
    if (cmd.node_rd) begin
      node_first_q  <= node_first_mem[cur_idx];
      node_second_q <= node_second_mem[cur_idx];
      node_tally_q  <= node_tally_mem[cur_idx];
      node_link_q   <= node_link_mem[cur_idx];
    end
  end

  // chain cursor and step count
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cur_r      <= head_vld_q ? LINK_W'(head_ptr_q) : LINK_W'(POOL_NODES);
      ins_link_r <= head_vld_q ? LINK_W'(head_ptr_q) : LINK_W'(POOL_NODES);
      steps_r    <= '0;
    end else if (cmd.advance) begin
      cur_r   <= node_link_q;
      steps_r <= steps_r + 1'b1;
    end
  end

  // pool fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_used_r <= '0;
    end else if (cmd.ins_wr) begin
      pool_used_r <= pool_used_r + 1'b1;
    end
  end

  // pending result, then output register
  always_ff @(posedge clk) begin
    if (cmd.hit_wr) begin
      pend_count_r  <= tally_inc;
      pend_status_r <= STATUS_HIT;
    end else if (cmd.ins_wr) begin
      pend_count_r  <= COUNT_BITS'(1);
      pend_status_r <= STATUS_NEW;
    end else if (cmd.drop) begin
      pend_count_r  <= '0;
      pend_status_r <= STATUS_DROP;
    end
    if (cmd.out_load) begin
      out_count_r  <= pend_count_r;
      out_status_r <= pend_status_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.div_last  = div_last;
    sts.clr_last  = (clr_cnt_r == BIDX_W'(MAX_BUCKETS - 1));
    sts.probe_ok  = (cur_r < pool_used_r) && (steps_r < pool_used_r);
    sts.key_match = (node_first_q == first_r) && (node_second_q == second_r);
    sts.pool_full = (pool_used_r >= LINK_W'(POOL_NODES));
  end

  assign out_pair_count = out_count_r;
  assign out_status     = out_status_r;

endmodule

// ----- rtl/core/pair_count_hash_table.sv -----
// pair_count_hash_table: top level of the chained hash table pair counter
// depends on pcht_pkg, instantiates pcht_ctrl and pcht_dpath
//
// Usage
//   Input channel in_valid/in_stall carries a pair (in_first_id, in_second_id).
//   Result channel out_valid/out_stall returns one result per pair: the pair's
//   count after the update (out_pair_count) and out_status (existing entry,
//   new entry, or dropped with count zero when the node pool is full).
//   cfg_wr_en/cfg_wr_data write the bucket count; write only while idle.
// Timing
//   One pair at a time. A pair is accepted, its ID_BITS+6 bit hash passes
//   through the bit-serial remainder unit for the bucket index, the head is
//   read, each chain node visited is read through the node memory read port
//   and compared, and a hit updates the matching node while a miss inserts
//   a new node or drops the pair. The remainder unit and the chain walk
//   set the time that a pair takes.
// Reset
//   After rst_n a clearing pass empties all MAX_BUCKETS bucket heads, one per
//   cycle; in_stall is high until it ends.
// Stall
//   A result waits in the output register while out_stall is high; the next
//   pair is still taken and held in its final step until the register frees.
module pair_count_hash_table import pcht_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned POOL_NODES  = 4096,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ID_BITS-1:0]    in_first_id,
  input  logic [ID_BITS-1:0]    in_second_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_BITS-1:0] out_pair_count,
  output status_t               out_status
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pcht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  pcht_dpath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_NODES  (POOL_NODES),
    .ID_BITS     (ID_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_first_id    (in_first_id),
    .in_second_id   (in_second_id),
    .out_pair_count (out_pair_count),
    .out_status     (out_status)
  );

  // an accepted pair keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  // a dropped pair reports count zero
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_DROP) |-> (out_pair_count == '0))
    else $error("dropped pair with nonzero count");

  // a new entry reports count one
  a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NEW) |-> (out_pair_count == COUNT_BITS'(1)))
    else $error("new entry with count other than one");

  // no result is loaded while the output register is stalled and full
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !cmd.out_load)
    else $error("result overwritten while stalled");

endmodule
